// ===== design/ledser_pkg.sv =====
// Shared types and constants for the addressable RGB LED serializer.
package ledser_pkg;

    localparam int PIX_W = 24;
    localparam int TICK_W = 16;
    localparam int TIME_W = 10;
    localparam int CNT_W = 6;
    localparam int OP_W = 3;
    localparam int FIELD_W = 8;
    localparam int BIT_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [BIT_W-1:0] BIT_TOP = 5'd23;

    localparam logic [TIME_W-1:0] RST_T0_HIGH = 10'd3;
    localparam logic [TIME_W-1:0] RST_T0_LOW = 10'd80;
    localparam logic [TIME_W-1:0] RST_T1_HIGH = 10'd60;
    localparam logic [TIME_W-1:0] RST_T1_LOW = 10'd30;
    localparam logic [TICK_W-1:0] RST_GAP = 16'd5000;
    localparam logic [CNT_W-1:0] RST_LED_COUNT = 6'd30;

    localparam logic [OP_W-1:0] OP_TICK = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_PIXEL = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_ALL = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_SHOW = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_T0_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_T0_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_T1_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_T1_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_GAP_LEAD,
        PH_HIGH,
        PH_LOW,
        PH_GAP_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        CTL_INIT,
        CTL_RUN,
        CTL_FILL
    } t_ctl;

endpackage

// ===== design/addressable_rgb_led_serializer.sv =====
// Addressable RGB LED strip serializer: pixel store and one-wire frame timing.
//
// Commands are taken at a clock edge with start high and busy low. Every
// command gives one result word, strobed by o_valid for one cycle; the
// receiver cannot stall it. Tick, set pixel and show: the result appears in
// the cycle after acceptance and the next command can be taken in that same
// cycle, so ticks can arrive every clock while no fill holds busy high. Set
// all and clear sweep the pixel memory one entry per cycle: busy stays high
// through the sweep and the result appears at the end of it. The sweep
// through the memory sets the rate of those two commands.
// During a frame the pixel memory is read every cycle at the next pixel
// pointer, so the current pixel word is always ready; the store is not
// written while a frame runs, so no forwarding is needed.
// After reset the memory is cleared by a pass over all MAX_LEDS entries with
// busy high; the data line is low. The timing registers are written over the
// config channel (o_cfg_ready is always high) and take effect at once.
module addressable_rgb_led_serializer
    import ledser_pkg::*;
#(
    parameter int MAX_LEDS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [FIELD_W-1:0]    i_index,
    input  logic [FIELD_W-1:0]    i_red,
    input  logic [FIELD_W-1:0]    i_green,
    input  logic [FIELD_W-1:0]    i_blue,
    output logic                  o_valid,
    output logic                  o_pin_level,
    output logic                  o_busy_res,
    output logic                  o_ignored,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW0 = $clog2(MAX_LEDS + 1);
    localparam int CMP_W = (CW0 > FIELD_W) ? CW0 + 1 : FIELD_W + 1;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_LEDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

    // configuration
    logic [TIME_W-1:0] r_t0_high, r_t0_low, r_t1_high, r_t1_low;
    logic [TICK_W-1:0] r_gap;
    logic [CNT_W-1:0]  r_led_count;

    // control and frame state
    t_ctl              r_ctl, n_ctl;
    logic [AW-1:0]     r_fill_addr, n_fill_addr;
    logic [PIX_W-1:0]  r_fill_val, n_fill_val;
    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [BIT_W-1:0]  r_bit, n_bit;

    // result word
    logic r_valid, n_valid;
    logic r_ignored, n_ignored;
    logic r_pin, r_busy_res;

    // pixel memory
    logic [PIX_W-1:0] mem [MAX_LEDS];
    logic [PIX_W-1:0] r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [PIX_W-1:0] mem_wdata;

    logic             accept;
    logic [PIX_W-1:0] colour;
    logic [CMP_W-1:0] active;
    logic             cur_bit;
    logic [TICK_W:0]  tick_inc;
    logic [TIME_W-1:0] bit_dur;
    logic [TICK_W:0]  dur;

    assign busy = (r_ctl != CTL_RUN);
    assign accept = start && !busy;
    assign colour = {i_green, i_red, i_blue};
    assign active = ({{(CMP_W-CNT_W){1'b0}}, r_led_count} > MAX_C)
                    ? MAX_C : CMP_W'(r_led_count);
    assign cur_bit = r_rdata[r_bit];
    assign tick_inc = {1'b0, r_tick} + 1'b1;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (r_phase)
            PH_HIGH: bit_dur = cur_bit ? r_t1_high : r_t0_high;
            default: bit_dur = cur_bit ? r_t1_low : r_t0_low;
        endcase
        if (r_phase == PH_GAP_LEAD || r_phase == PH_GAP_TAIL) begin
            dur = (r_gap == '0) ? (TICK_W+1)'(1) : {1'b0, r_gap};
        end else begin
            dur = (bit_dur == '0) ? (TICK_W+1)'(1) : (TICK_W+1)'(bit_dur);
        end
    end

    // control sequencer: reset clear pass, fills, memory writes
    always_comb begin
        n_ctl = r_ctl;
        n_fill_addr = r_fill_addr;
        n_fill_val = r_fill_val;
        mem_we = 1'b0;
        mem_waddr = r_fill_addr;
        mem_wdata = r_fill_val;
        case (r_ctl)
            CTL_INIT, CTL_FILL: begin
                mem_we = 1'b1;
                n_fill_addr = r_fill_addr + 1'b1;
                if (r_fill_addr == LAST_ADDR) begin
                    n_ctl = CTL_RUN;
                    n_fill_addr = '0;
                end
            end
            CTL_RUN: begin
                if (accept && r_phase == PH_IDLE) begin
                    case (i_operation)
                        OP_SET_PIXEL: begin
                            if (CMP_W'(i_index) < active) begin
                                mem_we = 1'b1;
                                mem_waddr = AW'(i_index);
                                mem_wdata = colour;
                            end
                        end
                        OP_SET_ALL: begin
                            n_ctl = CTL_FILL;
                            n_fill_val = colour;
                            n_fill_addr = '0;
                        end
                        OP_CLEAR: begin
                            n_ctl = CTL_FILL;
                            n_fill_val = '0;
                            n_fill_addr = '0;
                        end
                        default: ;
                    endcase
                end
            end
            default: n_ctl = CTL_RUN;
        endcase
    end

    // frame timing
    always_comb begin
        n_phase = r_phase;
        n_tick = r_tick;
        n_ptr = r_ptr;
        n_bit = r_bit;
        if (accept && i_operation == OP_TICK && r_phase != PH_IDLE) begin
            if (tick_inc < dur) begin
                n_tick = tick_inc[TICK_W-1:0];
            end else begin
                n_tick = '0;
                case (r_phase)
                    PH_GAP_LEAD: begin
                        n_ptr = '0;
                        n_bit = BIT_TOP;
                        n_phase = (active == '0) ? PH_GAP_TAIL : PH_HIGH;
                    end
                    PH_HIGH: n_phase = PH_LOW;
                    PH_LOW: begin
                        if (r_bit != '0) begin
                            n_bit = r_bit - 1'b1;
                            n_phase = PH_HIGH;
                        end else if (CMP_W'(r_ptr) + 1'b1 < active) begin
                            n_ptr = r_ptr + 1'b1;
                            n_bit = BIT_TOP;
                            n_phase = PH_HIGH;
                        end else begin
                            n_phase = PH_GAP_TAIL;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_ptr = '0;
                        n_bit = '0;
                    end
                endcase
            end
        end else if (accept && i_operation == OP_SHOW && r_phase == PH_IDLE) begin
            n_phase = PH_GAP_LEAD;
            n_tick = '0;
            n_ptr = '0;
            n_bit = '0;
        end
    end

    // result strobe and drop flag
    always_comb begin
        n_valid = 1'b0;
        n_ignored = 1'b0;
        if (r_ctl == CTL_FILL && r_fill_addr == LAST_ADDR) begin
            n_valid = 1'b1;
        end else if (accept) begin
            case (i_operation)
                OP_TICK: begin
                    n_valid = 1'b1;
                end
                OP_SET_PIXEL: begin
                    n_valid = 1'b1;
                    n_ignored = (r_phase != PH_IDLE) || !(CMP_W'(i_index) < active);
                end
                OP_SET_ALL, OP_CLEAR: begin
                    // a fill taken while idle reports at the end of its sweep; during a frame it is dropped
                    n_valid = (r_phase != PH_IDLE);
                    n_ignored = (r_phase != PH_IDLE);
                end
                OP_SHOW: begin
                    n_valid = 1'b1;
                    n_ignored = (r_phase != PH_IDLE);
                end
                default: begin
                    n_valid = 1'b1;
                    n_ignored = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        // read at the next pointer so the word matches r_ptr after the edge
        r_rdata <= mem[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_high <= RST_T0_HIGH;
            r_t0_low <= RST_T0_LOW;
            r_t1_high <= RST_T1_HIGH;
            r_t1_low <= RST_T1_LOW;
            r_gap <= RST_GAP;
            r_led_count <= RST_LED_COUNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_T0_HIGH: r_t0_high <= i_cfg_data[TIME_W-1:0];
                CFG_T0_LOW: r_t0_low <= i_cfg_data[TIME_W-1:0];
                CFG_T1_HIGH: r_t1_high <= i_cfg_data[TIME_W-1:0];
                CFG_T1_LOW: r_t1_low <= i_cfg_data[TIME_W-1:0];
                CFG_GAP: r_gap <= i_cfg_data;
                CFG_LED_COUNT: r_led_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= CTL_INIT;
            r_fill_addr <= '0;
            r_fill_val <= '0;
            r_phase <= PH_IDLE;
            r_tick <= '0;
            r_ptr <= '0;
            r_bit <= '0;
            r_valid <= 1'b0;
            r_ignored <= 1'b0;
            r_pin <= 1'b0;
            r_busy_res <= 1'b0;
        end else begin
            r_ctl <= n_ctl;
            r_fill_addr <= n_fill_addr;
            r_fill_val <= n_fill_val;
            r_phase <= n_phase;
            r_tick <= n_tick;
            r_ptr <= n_ptr;
            r_bit <= n_bit;
            r_valid <= n_valid;
            r_ignored <= n_ignored;
            r_pin <= (n_phase == PH_HIGH);
            r_busy_res <= (n_phase != PH_IDLE);
        end
    end

    assign o_valid = r_valid;
    assign o_pin_level = r_pin;
    assign o_busy_res = r_busy_res;
    assign o_ignored = r_ignored;

endmodule
